FILE: design/cfpp_pkg.sv
// ----------------------------------------------------------------------------
// cfpp_pkg
// Shared types, codes and a CRC helper for the framed packet parser.
// ----------------------------------------------------------------------------
package cfpp_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int StoreAw     = $clog2(MAX_PAYLOAD);

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [7:0]  LenLimit = 8'd32;
  localparam logic [7:0]  VerMax   = 8'd16;
  localparam logic [7:0]  FaultMax = 8'd32;

  // status codes
  localparam logic [1:0] StNeedMore = 2'd0;
  localparam logic [1:0] StComplete = 2'd1;
  localparam logic [1:0] StFrameErr = 2'd2;
  localparam logic [1:0] StCrcBad   = 2'd3;

  // fault codes
  localparam logic [1:0] FcOk       = 2'd0;
  localparam logic [1:0] FcUnknown  = 2'd1;
  localparam logic [1:0] FcBadLen   = 2'd2;
  localparam logic [1:0] FcCrcFail  = 2'd3;

  // register indexes
  localparam logic [2:0] RegStartCode = 3'd0;
  localparam logic [2:0] RegIdCommand = 3'd1;
  localparam logic [2:0] RegIdState   = 3'd2;
  localparam logic [2:0] RegIdHeart   = 3'd3;
  localparam logic [2:0] RegIdVersion = 3'd4;
  localparam logic [2:0] RegIdFault   = 3'd5;
  localparam logic [2:0] RegCmdLen    = 3'd6;
  localparam logic [2:0] RegStateLen  = 3'd7;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_CRCH,
    PH_CRCL
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_CRC,
    SQ_POST,
    SQ_READ,
    SQ_EMIT
  } seq_t;

  // one bit of the CCITT polynomial division
  function automatic logic [15:0] crc_shift(input logic [15:0] c);
    logic [15:0] s;
    s = {c[14:0], 1'b0};
    crc_shift = c[15] ? (s ^ CrcPoly) : s;
  endfunction

endpackage

FILE: design/crc_framed_packet_parser.sv
// ----------------------------------------------------------------------------
// crc_framed_packet_parser
// Byte-wise frame parser: start byte, id, length, payload, CRC16/CCITT-FALSE.
// ----------------------------------------------------------------------------
// Input channel: one rx_byte beat per accepted item (in_valid, in_stall).
// Output channel: one status beat per input byte, or, for a frame whose CRC
// matches and that carries payload, a run of payload beats ending in run_last.
// Configuration goes through the APB port (pready tied high), registers at
// byte address 4*i, read back on prdata.
// An id, length or payload byte that feeds the CRC is accepted, then passes
// through the bit-serial CRC unit (SQ_CRC) before its status is loaded into
// the output register (SQ_POST); every other byte (hunt, CRC bytes, a
// rejected id or length) goes straight from accept to the output load.
// A good frame with payload emits one beat per SQ_READ/SQ_EMIT pair from the
// registered payload memory, so its last CRC byte holds the input until the
// run ends. in_stall stays high while a byte is processed or a run is
// emitted.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits; one finished beat may sit in the register while the
// next byte is taken in.
// Reset clears the frame state to hunting and loads register defaults; the
// payload memory is not cleared, only bytes of the current frame are read.
// ----------------------------------------------------------------------------
module crc_framed_packet_parser (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // output beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  fault_code,
  output logic [7:0]  kind_code,
  output logic [5:0]  payload_length,
  output logic [4:0]  byte_index,
  output logic [7:0]  payload_byte,
  output logic        run_last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [7:0] start_code, id_command, id_state, id_heartbeat, id_version, id_fault;
  logic [5:0] command_length, state_length;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code     <= 8'd170;
      id_command     <= 8'd1;
      id_state       <= 8'd2;
      id_heartbeat   <= 8'd3;
      id_version     <= 8'd4;
      id_fault       <= 8'd5;
      command_length <= 6'd8;
      state_length   <= 6'd8;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        cfpp_pkg::RegStartCode: start_code     <= pwdata[7:0];
        cfpp_pkg::RegIdCommand: id_command     <= pwdata[7:0];
        cfpp_pkg::RegIdState:   id_state       <= pwdata[7:0];
        cfpp_pkg::RegIdHeart:   id_heartbeat   <= pwdata[7:0];
        cfpp_pkg::RegIdVersion: id_version     <= pwdata[7:0];
        cfpp_pkg::RegIdFault:   id_fault       <= pwdata[7:0];
        cfpp_pkg::RegCmdLen:    command_length <= pwdata[5:0];
        cfpp_pkg::RegStateLen:  state_length   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cfpp_pkg::RegStartCode: prdata = {24'd0, start_code};
      cfpp_pkg::RegIdCommand: prdata = {24'd0, id_command};
      cfpp_pkg::RegIdState:   prdata = {24'd0, id_state};
      cfpp_pkg::RegIdHeart:   prdata = {24'd0, id_heartbeat};
      cfpp_pkg::RegIdVersion: prdata = {24'd0, id_version};
      cfpp_pkg::RegIdFault:   prdata = {24'd0, id_fault};
      cfpp_pkg::RegCmdLen:    prdata = {26'd0, command_length};
      cfpp_pkg::RegStateLen:  prdata = {26'd0, state_length};
      default:                prdata = 32'd0;
    endcase
  end

  // frame state
  cfpp_pkg::phase_t phase, phase_next;
  logic [7:0]  kind_held, kind_next;
  logic [5:0]  length_held, length_next;
  logic [5:0]  bytes_taken, taken_next;
  logic [15:0] crc_running;
  logic [7:0]  crc_high_held, crc_high_next;

  // sequencer
  cfpp_pkg::seq_t sq, sq_next;
  logic [2:0]  bit_cnt;
  logic [4:0]  emit_idx;

  logic [1:0]  pend_status, pend_status_next;
  logic [1:0]  pend_fault, pend_fault_next;
  logic [7:0]  pend_kind, pend_kind_next;

  logic        accept, out_free, out_load;
  logic        clr, crc_load, do_emit, store_wr, emit_done;
  logic        id_known, len_ok, emit_last;

  logic [7:0]  store [cfpp_pkg::MAX_PAYLOAD];
  logic [7:0]  store_q;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign emit_last = ({1'b0, emit_idx} == (length_held - 6'd1));

  assign id_known = (rx_byte == id_command) || (rx_byte == id_state) ||
                    (rx_byte == id_heartbeat) || (rx_byte == id_version) ||
                    (rx_byte == id_fault);

  // first matching kind decides the length rule
  always_comb begin
    len_ok = 1'b0;
    if (rx_byte > cfpp_pkg::LenLimit) len_ok = 1'b0;
    else if (kind_held == id_command)   len_ok = (rx_byte == {2'b00, command_length});
    else if (kind_held == id_state)     len_ok = (rx_byte == {2'b00, state_length});
    else if (kind_held == id_heartbeat) len_ok = (rx_byte == 8'd0);
    else if (kind_held == id_version)   len_ok = (rx_byte <= cfpp_pkg::VerMax);
    else if (kind_held == id_fault)     len_ok = (rx_byte <= cfpp_pkg::FaultMax);
  end

  // per-byte parse decision, applied at the accept edge
  always_comb begin
    phase_next       = phase;
    kind_next        = kind_held;
    length_next      = length_held;
    taken_next       = bytes_taken;
    crc_high_next    = crc_high_held;
    pend_status_next = cfpp_pkg::StNeedMore;
    pend_fault_next  = cfpp_pkg::FcOk;
    pend_kind_next   = 8'd0;
    clr              = 1'b0;
    crc_load         = 1'b0;
    do_emit          = 1'b0;
    store_wr         = 1'b0;
    unique case (phase)
      cfpp_pkg::PH_HUNT: begin
        if (rx_byte == start_code) begin
          clr        = 1'b1;
          phase_next = cfpp_pkg::PH_ID;
        end
      end
      cfpp_pkg::PH_ID: begin
        if (!id_known) begin
          clr              = 1'b1;
          pend_status_next = cfpp_pkg::StFrameErr;
          pend_fault_next  = cfpp_pkg::FcUnknown;
        end else begin
          kind_next  = rx_byte;
          crc_load   = 1'b1;
          phase_next = cfpp_pkg::PH_LEN;
        end
      end
      cfpp_pkg::PH_LEN: begin
        if (!len_ok) begin
          clr              = 1'b1;
          pend_status_next = cfpp_pkg::StFrameErr;
          pend_fault_next  = cfpp_pkg::FcBadLen;
        end else begin
          length_next = rx_byte[5:0];
          crc_load    = 1'b1;
          phase_next  = (rx_byte == 8'd0) ? cfpp_pkg::PH_CRCH : cfpp_pkg::PH_DATA;
        end
      end
      cfpp_pkg::PH_DATA: begin
        store_wr   = (bytes_taken < 6'(cfpp_pkg::MAX_PAYLOAD));
        crc_load   = 1'b1;
        taken_next = bytes_taken + 6'd1;
        if (taken_next >= length_held) phase_next = cfpp_pkg::PH_CRCH;
      end
      cfpp_pkg::PH_CRCH: begin
        crc_high_next = rx_byte;
        phase_next    = cfpp_pkg::PH_CRCL;
      end
      cfpp_pkg::PH_CRCL: begin
        if ({crc_high_held, rx_byte} != crc_running) begin
          clr              = 1'b1;
          pend_status_next = cfpp_pkg::StCrcBad;
          pend_fault_next  = cfpp_pkg::FcCrcFail;
        end else if (length_held == 6'd0) begin
          clr              = 1'b1;
          pend_status_next = cfpp_pkg::StComplete;
          pend_kind_next   = kind_held;
        end else begin
          // kind and length stay for the run; cleared when it ends
          do_emit       = 1'b1;
          phase_next    = cfpp_pkg::PH_HUNT;
          taken_next    = 6'd0;
          crc_high_next = 8'd0;
        end
      end
      default: begin
        clr              = 1'b1;
        pend_status_next = cfpp_pkg::StFrameErr;
        pend_fault_next  = cfpp_pkg::FcBadLen;
      end
    endcase
    if (clr) begin
      kind_next     = 8'd0;
      length_next   = 6'd0;
      taken_next    = 6'd0;
      crc_high_next = 8'd0;
      if (phase != cfpp_pkg::PH_HUNT) phase_next = cfpp_pkg::PH_HUNT;
    end
  end

  assign emit_done = (sq == cfpp_pkg::SQ_EMIT) && out_free && emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= cfpp_pkg::PH_HUNT;
      kind_held     <= 8'd0;
      length_held   <= 6'd0;
      bytes_taken   <= 6'd0;
      crc_high_held <= 8'd0;
    end else if (accept) begin
      phase         <= phase_next;
      kind_held     <= kind_next;
      length_held   <= length_next;
      bytes_taken   <= taken_next;
      crc_high_held <= crc_high_next;
    end else if (emit_done) begin
      kind_held   <= 8'd0;
      length_held <= 6'd0;
    end
  end

  // bit-serial CRC unit: byte folded in at accept, one bit per cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_running <= cfpp_pkg::CrcInit;
    end else if (accept && (clr || do_emit)) begin
      crc_running <= cfpp_pkg::CrcInit;
    end else if (accept && crc_load) begin
      crc_running <= crc_running ^ {rx_byte, 8'h00};
    end else if (sq == cfpp_pkg::SQ_CRC) begin
      crc_running <= cfpp_pkg::crc_shift(crc_running);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= 3'd0;
    end else if (sq == cfpp_pkg::SQ_CRC) begin
      bit_cnt <= bit_cnt + 3'd1;
    end else begin
      bit_cnt <= 3'd0;
    end
  end

  // payload memory
  always_ff @(posedge clk) begin
    if (accept && store_wr) store[bytes_taken[cfpp_pkg::StoreAw-1:0]] <= rx_byte;
    store_q <= store[emit_idx];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= pend_status_next;
      pend_fault  <= pend_fault_next;
      pend_kind   <= pend_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= 5'd0;
    end else if (accept) begin
      emit_idx <= 5'd0;
    end else if ((sq == cfpp_pkg::SQ_EMIT) && out_free) begin
      emit_idx <= emit_idx + 5'd1;
    end
  end

  // sequencer next state
  always_comb begin
    sq_next = sq;
    unique case (sq)
      cfpp_pkg::SQ_IDLE: begin
        if (accept) begin
          if (do_emit)       sq_next = cfpp_pkg::SQ_READ;
          else if (crc_load) sq_next = cfpp_pkg::SQ_CRC;
          else               sq_next = cfpp_pkg::SQ_POST;
        end
      end
      cfpp_pkg::SQ_CRC:  if (bit_cnt == 3'd7) sq_next = cfpp_pkg::SQ_POST;
      cfpp_pkg::SQ_POST: if (out_free) sq_next = cfpp_pkg::SQ_IDLE;
      cfpp_pkg::SQ_READ: sq_next = cfpp_pkg::SQ_EMIT;
      cfpp_pkg::SQ_EMIT: begin
        if (out_free) sq_next = emit_last ? cfpp_pkg::SQ_IDLE : cfpp_pkg::SQ_READ;
      end
      default: sq_next = cfpp_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) sq <= cfpp_pkg::SQ_IDLE;
    else     sq <= sq_next;
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (sq)
      cfpp_pkg::SQ_IDLE: in_stall = 1'b0;
      cfpp_pkg::SQ_POST: out_load = out_free;
      cfpp_pkg::SQ_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sq == cfpp_pkg::SQ_EMIT) begin
        status         <= cfpp_pkg::StComplete;
        fault_code     <= cfpp_pkg::FcOk;
        kind_code      <= kind_held;
        payload_length <= length_held;
        byte_index     <= emit_idx;
        payload_byte   <= store_q;
        run_last       <= emit_last;
      end else begin
        status         <= pend_status;
        fault_code     <= pend_fault;
        kind_code      <= pend_kind;
        payload_length <= 6'd0;
        byte_index     <= 5'd0;
        payload_byte   <= 8'd0;
        run_last       <= 1'b1;
      end
    end
  end

endmodule
